/* rtl/core/multi_pool_slot_allocator_assert.svh */
// Assertion macros shared by the checker files of the slot allocator.
// Each macro expands to one labelled concurrent assertion on clk, cut off during rst.
`ifndef MULTI_POOL_SLOT_ALLOCATOR_ASSERT_SVH
`define MULTI_POOL_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define MPSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication.
`define MPSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

/* rtl/core/mpsa_pkg.sv */
// Package of the multi-pool slot allocator: payload structs, codes and
// the command and status types between controller and datapath. No dependencies.
`default_nettype none
package mpsa_pkg;

  // Pool count and pool size are fixed by the widths of the payload fields.
  localparam int NUM_POOLS  = 8;
  localparam int POOL_SLOTS = 64;

  typedef struct packed {
    logic       action;
    logic [2:0] pool_index;
    logic [5:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] granted_pool;
    logic [5:0] granted_slot;
  } rsp_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] STATUS_ALLOC   = 2'd0;
  localparam logic [1:0] STATUS_FREED   = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;
  localparam logic [1:0] STATUS_NO_POOL = 2'd3;

  localparam logic [2:0] ADDR_CAPACITY = 3'd0;
  localparam logic [6:0] CAPACITY_RESET = 7'd64;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_OPEN_FIRST, CMD_SRCH_INIT, CMD_STEP, CMD_FOUND,
    CMD_NEW_POOL, CMD_SWAP1, CMD_SWAP2, CMD_SWAP3, CMD_GRANT, CMD_LINK, CMD_FAIL,
    CMD_FREE_INIT, CMD_WALK, CMD_WALK_NEXT, CMD_TRIM, CMD_LINK_SLOT, CMD_LINK_PREV,
    CMD_IGNORE, CMD_EMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic pools_zero;
    logic cur_ready;
    logic hit_list;
    logic hit_room;
    logic i_last;
    logic pools_full;
    logic fl_take;
    logic free_bad;
    logic walk_go;
    logic cur_eq_slot;
    logic top_slot;
    logic out_pending;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/core/multi_pool_slot_allocator.sv */
// Multi-pool slot allocator, top level.
// Allocate or free requests arrive on req (valid/ready) and each gives one
// result on rsp (valid/ready). One request is worked on at a time.
// An allocation that fits the current pool goes from the start check to the
// grant, with a link step after it when the slot comes from a free list; when
// the current pool is full a search walks the open pools once for a free list
// and once for room, one pool a cycle. A free walks the pool's free list one
// entry at a time, with a wait state for each read of the registered link
// memory. The result sits in an output register, so a stalled receiver holds
// one result while the next request is worked on; the block waits only when a
// second result is ready and the first is still held. A synchronous reset
// closes all pools and empties the free lists at once; pool_capacity returns
// to 64. The capacity register is at APB address 0 and must be written only
// while the block is idle; the block itself does not enforce this.
// Depends on mpsa_pkg, mpsa_ctrl and mpsa_dp.
`default_nettype none
module multi_pool_slot_allocator import mpsa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp
);

  logic [6:0] pool_capacity;
  dp_cmd_t    cmd;
  dp_status_t st;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? 32'(pool_capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
      pool_capacity <= pwdata[6:0];
    end
  end

  mpsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_free  (req.action == ACT_FREE),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mpsa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req           (req),
    .pool_capacity (pool_capacity),
    .st            (st),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp)
  );

endmodule
`default_nettype wire

/* rtl/core/mpsa_ctrl.sv */
// Controller state machine of the slot allocator.
// Uses mpsa_pkg; drives datapath commands from the datapath status.
`default_nettype none
module mpsa_ctrl import mpsa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic       req_free,
  output logic            req_ready,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_START = 15'b000000000000010,
    S_SRCH1 = 15'b000000000000100,
    S_SRCH2 = 15'b000000000001000,
    S_SWAP1 = 15'b000000000010000,
    S_SWAP2 = 15'b000000000100000,
    S_SWAP3 = 15'b000000001000000,
    S_GRANT = 15'b000000010000000,
    S_LINK  = 15'b000000100000000,
    S_FCHK  = 15'b000001000000000,
    S_WALK  = 15'b000010000000000,
    S_WAIT  = 15'b000100000000000,
    S_DEC   = 15'b001000000000000,
    S_LINKP = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = CMD_NONE;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = req_free ? S_FCHK : S_START;
        end
      end
      S_START: begin
        if (st.pools_zero) begin
          cmd.op     = CMD_OPEN_FIRST;
          state_next = S_GRANT;
        end else if (st.cur_ready) begin
          state_next = S_GRANT;
        end else begin
          cmd.op     = CMD_SRCH_INIT;
          state_next = S_SRCH1;
        end
      end
      S_SRCH1: begin
        if (st.hit_list) begin
          cmd.op     = CMD_FOUND;
          state_next = S_SWAP1;
        end else if (st.i_last) begin
          cmd.op     = CMD_SRCH_INIT;
          state_next = S_SRCH2;
        end else begin
          cmd.op = CMD_STEP;
        end
      end
      S_SRCH2: begin
        if (st.hit_room) begin
          cmd.op     = CMD_FOUND;
          state_next = S_SWAP1;
        end else if (st.i_last) begin
          if (st.pools_full) begin
            cmd.op     = CMD_FAIL;
            state_next = S_FIN;
          end else begin
            cmd.op     = CMD_NEW_POOL;
            state_next = S_SWAP1;
          end
        end else begin
          cmd.op = CMD_STEP;
        end
      end
      S_SWAP1: begin
        cmd.op     = CMD_SWAP1;
        state_next = S_SWAP2;
      end
      S_SWAP2: begin
        cmd.op     = CMD_SWAP2;
        state_next = S_SWAP3;
      end
      S_SWAP3: begin
        cmd.op     = CMD_SWAP3;
        state_next = S_GRANT;
      end
      S_GRANT: begin
        cmd.op     = CMD_GRANT;
        state_next = st.fl_take ? S_LINK : S_FIN;
      end
      S_LINK: begin
        cmd.op     = CMD_LINK;
        state_next = S_FIN;
      end
      S_FCHK: begin
        if (st.free_bad) begin
          cmd.op     = CMD_IGNORE;
          state_next = S_FIN;
        end else begin
          cmd.op     = CMD_FREE_INIT;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (st.walk_go) begin
          cmd.op     = CMD_WALK;
          state_next = S_WAIT;
        end else begin
          state_next = S_DEC;
        end
      end
      S_WAIT: begin
        cmd.op     = CMD_WALK_NEXT;
        state_next = S_WALK;
      end
      S_DEC: begin
        if (st.cur_eq_slot) begin
          cmd.op     = CMD_IGNORE;
          state_next = S_FIN;
        end else if (st.top_slot) begin
          cmd.op     = CMD_TRIM;
          state_next = S_FIN;
        end else begin
          cmd.op     = CMD_LINK_SLOT;
          state_next = S_LINKP;
        end
      end
      S_LINKP: begin
        cmd.op     = CMD_LINK_PREV;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!st.out_pending) begin
          cmd.op     = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/mpsa_dp.sv */
// Datapath of the slot allocator: pool tables, link memory and result register.
// Uses mpsa_pkg; acts on commands from mpsa_ctrl and reports status back.
`default_nettype none
module mpsa_dp import mpsa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_cmd_t    cmd,
  input  wire req_t       req,
  input  wire logic [6:0] pool_capacity,
  output dp_status_t      st,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output rsp_t            rsp
);

  localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int SW    = $clog2(POOL_SLOTS);
  localparam int LW    = $clog2(2 * POOL_SLOTS);
  localparam int CW    = $clog2(POOL_SLOTS + 1);
  localparam int OW    = $clog2(NUM_POOLS + 1);
  localparam int DEPTH = NUM_POOLS * POOL_SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [LW-1:0] LINK_END = LW'(2 * POOL_SLOTS - 1);

  logic [OW-1:0] pools_open;
  logic [PW-1:0] pool_order [NUM_POOLS];
  logic [LW-1:0] free_head  [NUM_POOLS];
  logic [CW-1:0] used_count [NUM_POOLS];
  logic [LW-1:0] slot_link  [DEPTH];

  logic [PW-1:0] i, found, tmp, p_r;
  logic [2:0]    pool_in;
  logic [5:0]    slot_in;
  logic [SW-1:0] slot_r, prev;
  logic [LW-1:0] cur;
  logic          has_prev;
  logic [CW-1:0] guard;
  logic [1:0]    res_status;
  logic [2:0]    res_pool;
  logic [5:0]    res_slot;
  logic [LW-1:0] rd_data;

  logic [CW-1:0] cap_eff;
  logic [PW-1:0] last, ord_i, ord_last, pf;
  logic [SW-1:0] slot_s;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [LW-1:0] mem_wdata;

  function automatic logic [LW-1:0] next_free(logic [SW-1:0] c, logic [LW-1:0] l);
    logic [LW:0] n;
    n = (LW+1)'(c) + (LW+1)'(l);
    if (l == LINK_END || l == '0) return LINK_END;
    if (n >= (LW+1)'(POOL_SLOTS)) return LINK_END;
    return LW'(n);
  endfunction

  function automatic logic [AW-1:0] mk_addr(logic [PW-1:0] p, logic [SW-1:0] s);
    return AW'(p) * AW'(POOL_SLOTS) + AW'(s);
  endfunction

  always_comb begin
    if (pool_capacity == '0) begin
      cap_eff = CW'(1);
    end else if (32'(pool_capacity) > POOL_SLOTS) begin
      cap_eff = CW'(POOL_SLOTS);
    end else begin
      cap_eff = CW'(pool_capacity);
    end
  end

  assign last     = PW'(pools_open - OW'(1));
  assign ord_i    = pool_order[i];
  assign ord_last = pool_order[last];
  assign pf       = PW'(pool_in);
  assign slot_s   = SW'(slot_in);

  always_comb begin
    st.pools_zero  = (pools_open == '0);
    st.cur_ready   = (free_head[ord_last] != LINK_END) || (used_count[ord_last] < cap_eff);
    st.hit_list    = (free_head[ord_i] != LINK_END);
    st.hit_room    = (used_count[ord_i] < cap_eff);
    st.i_last      = (i == last);
    st.pools_full  = (32'(pools_open) >= NUM_POOLS);
    st.fl_take     = (free_head[ord_last] != LINK_END) &&
                     (32'(free_head[ord_last]) < POOL_SLOTS);
    st.free_bad    = (32'(pool_in) >= NUM_POOLS) ||
                     (32'(slot_in) >= 32'(used_count[pf])) ||
                     (32'(slot_in) >= POOL_SLOTS);
    st.walk_go     = (32'(guard) < POOL_SLOTS) && (cur != LINK_END) &&
                     (cur < LW'(slot_s));
    st.cur_eq_slot = (cur == LW'(slot_s));
    st.top_slot    = (32'(slot_s) + 32'd1 == 32'(used_count[p_r]));
    st.out_pending = rsp_valid && !rsp_ready;
  end

  // Link memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = mk_addr(p_r, slot_s);
    mem_raddr = mk_addr(p_r, SW'(cur));
    mem_wdata = (cur == LINK_END) ? LINK_END : LW'(cur - LW'(slot_s));
    case (cmd.op)
      CMD_GRANT: begin
        mem_re    = st.fl_take;
        mem_raddr = mk_addr(ord_last, SW'(free_head[ord_last]));
      end
      CMD_WALK: begin
        mem_re = 1'b1;
      end
      CMD_LINK_SLOT: begin
        mem_we = 1'b1;
      end
      CMD_LINK_PREV: begin
        mem_we    = has_prev;
        mem_waddr = mk_addr(p_r, prev);
        mem_wdata = LW'(slot_s) - LW'(prev);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_link[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= slot_link[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pools_open <= '0;
      rsp_valid  <= 1'b0;
      for (int k = 0; k < NUM_POOLS; k++) begin
        pool_order[k] <= PW'(k);
        free_head[k]  <= LINK_END;
        used_count[k] <= '0;
      end
    end else begin
      // A new result is only emitted once the previous one has gone.
      if (cmd.op == CMD_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (cmd.op)
        CMD_OPEN_FIRST: pools_open <= OW'(1);
        CMD_NEW_POOL:   pools_open <= pools_open + OW'(1);
        CMD_SWAP2:      pool_order[found] <= ord_last;
        CMD_SWAP3:      pool_order[last] <= tmp;
        CMD_GRANT: begin
          if (!st.fl_take) begin
            free_head[ord_last] <= LINK_END;
            if (32'(used_count[ord_last]) < POOL_SLOTS) begin
              used_count[ord_last] <= used_count[ord_last] + CW'(1);
            end
          end
        end
        CMD_LINK:      free_head[p_r] <= next_free(slot_r, rd_data);
        CMD_TRIM:      used_count[p_r] <= CW'(slot_s);
        CMD_LINK_PREV: begin
          if (!has_prev) begin
            free_head[p_r] <= LW'(slot_s);
          end
        end
        default: begin
          pools_open <= pools_open;
        end
      endcase
    end
  end

  // Working registers and the result; no reset needed.
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        pool_in    <= req.pool_index;
        slot_in    <= req.slot_index;
        res_status <= STATUS_ALLOC;
        res_pool   <= '0;
        res_slot   <= '0;
      end
      CMD_SRCH_INIT: i <= '0;
      CMD_STEP:      i <= i + PW'(1);
      CMD_FOUND:     found <= i;
      CMD_NEW_POOL:  found <= PW'(pools_open);
      CMD_SWAP1:     tmp <= pool_order[found];
      CMD_GRANT: begin
        p_r <= ord_last;
        if (st.fl_take) begin
          slot_r   <= SW'(free_head[ord_last]);
          res_pool <= 3'(ord_last);
          res_slot <= 6'(free_head[ord_last]);
        end else if (32'(used_count[ord_last]) >= POOL_SLOTS) begin
          res_status <= STATUS_NO_POOL;
        end else begin
          res_pool <= 3'(ord_last);
          res_slot <= 6'(used_count[ord_last]);
        end
      end
      CMD_FAIL: res_status <= STATUS_NO_POOL;
      CMD_FREE_INIT: begin
        cur      <= (32'(free_head[pf]) >= POOL_SLOTS) ? LINK_END : free_head[pf];
        has_prev <= 1'b0;
        guard    <= '0;
        p_r      <= pf;
      end
      CMD_WALK: begin
        prev     <= SW'(cur);
        has_prev <= 1'b1;
        guard    <= guard + CW'(1);
      end
      CMD_WALK_NEXT: cur <= next_free(prev, rd_data);
      CMD_TRIM:      res_status <= STATUS_FREED;
      CMD_LINK_PREV: res_status <= STATUS_FREED;
      CMD_IGNORE:    res_status <= STATUS_IGNORED;
      CMD_EMIT: begin
        rsp.status       <= res_status;
        rsp.granted_pool <= res_pool;
        rsp.granted_slot <= res_slot;
      end
      default: begin
        tmp <= tmp;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/mpsa_checker.sv */
// Port checker of the slot allocator, bound to the top level.
// Uses mpsa_pkg and the macros of multi_pool_slot_allocator_assert.svh.
`default_nettype none
`include "multi_pool_slot_allocator_assert.svh"
module mpsa_checker import mpsa_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  // A held result keeps its value.
  `MPSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // Only a granted slot carries a pool and slot number.
  `MPSA_ASSERT_IMP(a_rsp_zero, rsp_valid && rsp.status != STATUS_ALLOC, rsp.granted_pool == 3'd0 && rsp.granted_slot == 6'd0)

  // Requests are worked on one at a time.
  `MPSA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind multi_pool_slot_allocator mpsa_checker u_mpsa_checker (.*);
`default_nettype wire
